// ===== hdl/dws_pkg.sv =====
`timescale 1ns / 1ps

package dws_pkg;

  // Storage geometry
  localparam int DEPTH  = 64;
  localparam int WORD_W = 32;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  localparam logic [CNT_W-1:0]  DEPTH_CNT  = CNT_W'(DEPTH);
  localparam logic [CNT_W:0]    DEPTH_WIDE = (CNT_W + 1)'(DEPTH);
  localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(DEPTH - 1);

  // Operation codes carried on kind
  localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [2:0] KIND_POP_BACK   = 3'd3;
  localparam logic [2:0] KIND_CONTAINS   = 3'd4;
  localparam logic [2:0] KIND_REMOVE     = 3'd5;

  // Status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_EMPTY     = 2'd1;
  localparam logic [1:0] STATUS_FULL      = 2'd2;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

endpackage

// ===== hdl/dws_ram.sv =====
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port, registered read data.
module dws_ram #(
  parameter int Depth = 64,
  parameter int Width = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/deque_with_search.sv =====
`timescale 1ns / 1ps

// Bounded double-ended queue of 64 signed 32-bit words that also answers
// membership queries and removes the first occurrence of a value. Issue a
// word by raising start while busy is low; kind and value are sampled at that
// edge. Exactly one result word follows, shown for a single cycle with done
// high; it cannot be held off, so capture it in that cycle. Pushes, pops and
// unused kinds pass through the execute, front read, back read and finish
// states before busy falls (done comes with the first cycle in which busy is
// low again). Contains adds a scan step per entry examined, up to the count
// held; remove adds the same scan up to and including the match, plus a copy
// step per entry behind it and a final step to drop the entry, since later
// entries are copied one place forward through the single read and single
// write port of the entry RAM. Front and back values are read back from the
// RAM after every operation and reported as zero when the queue is empty.
// Entries live in a ring addressed from the head pointer; no clearing pass is
// needed after reset.
module deque_with_search (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         kind,
  input  logic signed [31:0] value,
  output logic               done,
  output logic [1:0]         status,
  output logic               found,
  output logic signed [31:0] front_value,
  output logic signed [31:0] back_value,
  output logic [6:0]         count,
  output logic               is_empty
);

  localparam int AW = dws_pkg::ADDR_W;
  localparam int CW = dws_pkg::CNT_W;
  localparam int WW = dws_pkg::WORD_W;

  localparam logic [CW-1:0] ONE = CW'(1);
  localparam logic [CW-1:0] TWO = CW'(2);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_SHIFT,
    ST_RD_FRONT,
    ST_RD_BACK,
    ST_FINISH
  } state_t;

  state_t        state;
  logic [2:0]    kind_q;
  logic [WW-1:0] value_q;
  logic [AW-1:0] head;
  logic [CW-1:0] entry_count;
  logic [CW-1:0] idx;
  logic [1:0]    op_status;
  logic          op_found;
  logic [WW-1:0] front_q;

  // RAM port signals
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [WW-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [WW-1:0] ram_rdata;

  logic          is_full;
  logic          is_none;
  logic [AW-1:0] head_dec;
  logic [AW-1:0] head_inc;
  logic [CW-1:0] last_off;
  logic          hit;
  logic          shift_more;

  // Ring position of an offset from the head; offset never exceeds DEPTH + 1.
  function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] base,
                                              input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW + 1)'(base) + (CW + 1)'(off);
    if (sum >= dws_pkg::DEPTH_WIDE) begin
      sum = sum - dws_pkg::DEPTH_WIDE;
    end
    return sum[AW-1:0];
  endfunction

  assign is_full    = (entry_count == dws_pkg::DEPTH_CNT);
  assign is_none    = (entry_count == '0);
  assign head_dec   = (head == '0) ? dws_pkg::LAST_ADDR : head - AW'(1);
  assign head_inc   = (head == dws_pkg::LAST_ADDR) ? '0 : head + AW'(1);
  assign last_off   = is_none ? '0 : entry_count - ONE;
  assign hit        = (ram_rdata == value_q);
  assign shift_more = ((idx + ONE) < entry_count);
  assign busy       = (state != ST_IDLE);

  dws_ram #(
    .Depth (dws_pkg::DEPTH),
    .Width (WW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // RAM access per state. The scan always reads one entry ahead, so on a
  // match the successor is already on its way for the close-up copy.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ring_addr(head, entry_count);
    ram_wdata = value_q;
    ram_re    = 1'b0;
    ram_raddr = ring_addr(head, '0);
    case (state)
      ST_EXEC: begin
        case (kind_q)
          dws_pkg::KIND_PUSH_FRONT: begin
            ram_we    = !is_full;
            ram_waddr = head_dec;
          end
          dws_pkg::KIND_PUSH_BACK: begin
            ram_we    = !is_full;
          end
          dws_pkg::KIND_CONTAINS, dws_pkg::KIND_REMOVE: begin
            ram_re    = !is_none;
          end
          default: begin
          end
        endcase
      end
      ST_SCAN: begin
        ram_re    = 1'b1;
        ram_raddr = ring_addr(head, idx + ONE);
      end
      ST_SHIFT: begin
        // copy entry idx+1 into idx, and fetch idx+2 for the next step
        ram_we    = shift_more;
        ram_waddr = ring_addr(head, idx);
        ram_wdata = ram_rdata;
        ram_re    = shift_more;
        ram_raddr = ring_addr(head, idx + TWO);
      end
      ST_RD_FRONT: begin
        ram_re    = 1'b1;
      end
      ST_RD_BACK: begin
        ram_re    = 1'b1;
        ram_raddr = ring_addr(head, last_off);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      head        <= '0;
      entry_count <= '0;
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            kind_q    <= kind;
            value_q   <= $unsigned(value);
            op_status <= dws_pkg::STATUS_OK;
            op_found  <= 1'b0;
            idx       <= '0;
            state     <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state <= ST_RD_FRONT;
          case (kind_q)
            dws_pkg::KIND_PUSH_FRONT: begin
              if (is_full) begin
                op_status <= dws_pkg::STATUS_FULL;
              end else begin
                head        <= head_dec;
                entry_count <= entry_count + ONE;
              end
            end
            dws_pkg::KIND_PUSH_BACK: begin
              if (is_full) begin
                op_status <= dws_pkg::STATUS_FULL;
              end else begin
                entry_count <= entry_count + ONE;
              end
            end
            dws_pkg::KIND_POP_FRONT: begin
              if (is_none) begin
                op_status <= dws_pkg::STATUS_EMPTY;
              end else begin
                head        <= head_inc;
                entry_count <= entry_count - ONE;
              end
            end
            dws_pkg::KIND_POP_BACK: begin
              if (is_none) begin
                op_status <= dws_pkg::STATUS_EMPTY;
              end else begin
                entry_count <= entry_count - ONE;
              end
            end
            dws_pkg::KIND_CONTAINS, dws_pkg::KIND_REMOVE: begin
              if (is_none) begin
                if (kind_q == dws_pkg::KIND_REMOVE) begin
                  op_status <= dws_pkg::STATUS_NOT_FOUND;
                end
              end else begin
                state <= ST_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
        ST_SCAN: begin
          // read data belongs to offset idx
          if (hit) begin
            op_found <= 1'b1;
            state    <= (kind_q == dws_pkg::KIND_REMOVE) ? ST_SHIFT : ST_RD_FRONT;
          end else if ((idx + ONE) == entry_count) begin
            if (kind_q == dws_pkg::KIND_REMOVE) begin
              op_status <= dws_pkg::STATUS_NOT_FOUND;
            end
            state <= ST_RD_FRONT;
          end else begin
            idx <= idx + ONE;
          end
        end
        ST_SHIFT: begin
          if (shift_more) begin
            idx <= idx + ONE;
          end else begin
            entry_count <= entry_count - ONE;
            state       <= ST_RD_FRONT;
          end
        end
        ST_RD_FRONT: begin
          state <= ST_RD_BACK;
        end
        ST_RD_BACK: begin
          front_q <= ram_rdata;
          state   <= ST_FINISH;
        end
        ST_FINISH: begin
          done        <= 1'b1;
          status      <= op_status;
          found       <= op_found;
          front_value <= $signed(is_none ? '0 : front_q);
          back_value  <= $signed(is_none ? '0 : ram_rdata);
          count       <= entry_count;
          is_empty    <= is_none;
          state       <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Hold the fill level within the ring.
  assert property (@(posedge clk) disable iff (rst)
    entry_count <= dws_pkg::DEPTH_CNT)
    else $error("entry count beyond depth");

  // Drop no word: an accepted word makes the block busy in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not start an operation");

  // Emit a result only straight out of the finishing step.
  assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == ST_FINISH) && !busy)
    else $error("result strobe without a finished operation");

  // Report a match only with an ok status.
  assert property (@(posedge clk) disable iff (rst)
    (done && found) |-> (status == dws_pkg::STATUS_OK))
    else $error("found flag with a failing status");

  // Keep the empty flag consistent with the reported count.
  assert property (@(posedge clk) disable iff (rst)
    done |-> (is_empty == (count == '0)))
    else $error("empty flag disagrees with count");

endmodule
